FILE: design/ffpa_pkg.sv
package ffpa_pkg;

	// Payload and address widths fixed by the interface.
	localparam int ADDR_W = 20;
	localparam int REQ_W  = 21;
	localparam int STAT_W = 3;

	// Default configuration.
	localparam int DEF_POOL_BYTES   = 1024 * 1024;
	localparam int DEF_HEADER_BYTES = 24;
	localparam int DEF_MAX_BLOCKS   = 64;

	// Command codes.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_ALLOCATED = 3'd0;
	localparam logic [STAT_W-1:0] ST_NO_MEMORY = 3'd1;
	localparam logic [STAT_W-1:0] ST_FREED     = 3'd2;
	localparam logic [STAT_W-1:0] ST_NULL      = 3'd3;
	localparam logic [STAT_W-1:0] ST_BAD       = 3'd4;

	// One entry of the block table.
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] size;
		logic              is_free;
	} entry_t;

	// Write request into the block table.
	typedef struct packed {
		logic              en;
		logic [9:0]        addr;
		entry_t            data;
	} tbl_wr_t;

endpackage

FILE: design/first_fit_pool_allocator.sv
// Operation: the table is scanned entry by entry, each with a read and a check; a split or
// merge then shifts the following entries one by one before the result is output.
// Throughput: one item at a time; the next item is accepted in the cycle after the result
// is loaded into the output register. The single table read port sets the pace.
// Reset: asynchronous, active low; the table holds one free block spanning the pool.
module first_fit_pool_allocator #(
	parameter int POOL_BYTES   = ffpa_pkg::DEF_POOL_BYTES,
	parameter int HEADER_BYTES = ffpa_pkg::DEF_HEADER_BYTES,
	parameter int MAX_BLOCKS   = ffpa_pkg::DEF_MAX_BLOCKS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [ffpa_pkg::REQ_W-1:0]    req_size,
	input  logic [ffpa_pkg::ADDR_W-1:0]   free_addr,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ffpa_pkg::STAT_W-1:0]   status,
	output logic [ffpa_pkg::ADDR_W-1:0]   alloc_addr
);
	import ffpa_pkg::*;

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [ADDR_W-1:0] HDR = ADDR_W'(HEADER_BYTES);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

	// Sequencer states.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_NCK  = 4'd3;
	localparam logic [3:0] S_PCK  = 4'd4;
	localparam logic [3:0] S_FIN  = 4'd5;
	localparam logic [3:0] S_SDR  = 4'd6;
	localparam logic [3:0] S_SDW  = 4'd7;
	localparam logic [3:0] S_SUR  = 4'd8;
	localparam logic [3:0] S_SUW  = 4'd9;
	localparam logic [3:0] S_SPL  = 4'd10;
	localparam logic [3:0] S_SPL2 = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	logic [3:0]        state_q;
	logic              cmd_q;
	logic [REQ_W-1:0]  req_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     k_q;
	logic [CW-1:0]     t_q;
	logic [CW-1:0]     cnt_q;
	logic [1:0]        d_q;
	entry_t            cur_q;
	logic [STAT_W-1:0] res_st_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_st_q;
	logic [ADDR_W-1:0] out_addr_q;

	tbl_wr_t           wr;
	logic [CW-1:0]     rd_idx;
	entry_t            rd_data;

	logic              fits;
	logic              splits;
	logic              hit;
	logic              last;

	ffpa_table #(
		.POOL_BYTES(POOL_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.rd_addr(rd_idx[IW-1:0]),
		.rd_data(rd_data)
	);

	// Compares on the entry just read.
	assign fits   = rd_data.is_free && ({1'b0, rd_data.size} >= req_q);
	assign splits = ({2'b0, rd_data.size} > ({1'b0, req_q} + (REQ_W+1)'(HEADER_BYTES)))
		&& (cnt_q < MAXC);
	assign hit    = ({1'b0, rd_data.start} + REQ_W'(HEADER_BYTES)) == {1'b0, addr_q};
	assign last   = (i_q + 1'b1) == cnt_q;

	// Read address selection.
	always_comb begin
		rd_idx = i_q;
		unique case (state_q)
			S_CHK:   rd_idx = (!last) ? i_q + 1'b1 : i_q - 1'b1;
			S_NCK:   rd_idx = i_q - 1'b1;
			S_SDR:   rd_idx = k_q + CW'(d_q);
			S_SUR:   rd_idx = k_q - 1'b1;
			default: rd_idx = i_q;
		endcase
	end

	// Table write port.
	always_comb begin
		wr = '0;
		unique case (state_q)
			S_CHK: begin
				if (cmd_q == CMD_ALLOC && fits && !splits) begin
					wr.en   = 1'b1;
					wr.addr = 10'(i_q);
					wr.data = '{start: rd_data.start, size: rd_data.size, is_free: 1'b0};
				end
			end
			S_FIN: begin
				wr.en   = 1'b1;
				wr.addr = 10'(t_q);
				wr.data = '{start: cur_q.start, size: cur_q.size, is_free: 1'b1};
			end
			S_SDW: begin
				wr.en   = 1'b1;
				wr.addr = 10'(k_q);
				wr.data = rd_data;
			end
			S_SUW: begin
				wr.en   = 1'b1;
				wr.addr = 10'(k_q);
				wr.data = rd_data;
			end
			S_SPL: begin
				wr.en   = 1'b1;
				wr.addr = 10'(i_q + 1'b1);
				wr.data = '{start: cur_q.start + HDR + req_q[ADDR_W-1:0],
					size: cur_q.size - req_q[ADDR_W-1:0] - HDR, is_free: 1'b1};
			end
			S_SPL2: begin
				wr.en   = 1'b1;
				wr.addr = 10'(i_q);
				wr.data = '{start: cur_q.start, size: req_q[ADDR_W-1:0], is_free: 1'b0};
			end
			default: wr = '0;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= CW'(1);
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q  <= cmd;
						req_q  <= req_size;
						addr_q <= free_addr;
						i_q    <= '0;
						d_q    <= '0;
						if (cmd == CMD_FREE && free_addr == '0) begin
							res_st_q   <= ST_NULL;
							res_addr_q <= '0;
							state_q    <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					res_addr_q <= '0;
					if (cmd_q == CMD_ALLOC) begin
						if (fits) begin
							cur_q      <= rd_data;
							res_st_q   <= ST_ALLOCATED;
							res_addr_q <= rd_data.start + HDR;
							if (splits) begin
								k_q     <= cnt_q;
								state_q <= S_SUR;
							end else begin
								state_q <= S_DONE;
							end
						end else if (last) begin
							res_st_q <= ST_NO_MEMORY;
							state_q  <= S_DONE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_RD;
						end
					end else begin
						if (hit) begin
							cur_q <= rd_data;
							t_q   <= i_q;
							if (rd_data.is_free) begin
								res_st_q <= ST_BAD;
								state_q  <= S_DONE;
							end else begin
								res_st_q <= ST_FREED;
								if (!last) begin
									state_q <= S_NCK;
								end else if (i_q != '0) begin
									state_q <= S_PCK;
								end else begin
									state_q <= S_FIN;
								end
							end
						end else if (last) begin
							res_st_q <= ST_BAD;
							state_q  <= S_DONE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				// Merge with the next neighbor.
				S_NCK: begin
					if (rd_data.is_free) begin
						cur_q.size <= cur_q.size + rd_data.size + HDR;
						d_q        <= 2'd1;
					end
					state_q <= (i_q != '0) ? S_PCK : S_FIN;
				end
				// Merge into the previous neighbor.
				S_PCK: begin
					if (rd_data.is_free) begin
						cur_q.start <= rd_data.start;
						cur_q.size  <= rd_data.size + cur_q.size + HDR;
						t_q         <= i_q - 1'b1;
						d_q         <= d_q + 2'd1;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					k_q     <= t_q + 1'b1;
					state_q <= (d_q == '0) ? S_DONE : S_SDR;
				end
				// Close the gap left by merged entries.
				S_SDR: begin
					if ((k_q + CW'(d_q)) >= cnt_q) begin
						cnt_q   <= cnt_q - CW'(d_q);
						state_q <= S_DONE;
					end else begin
						state_q <= S_SDW;
					end
				end
				S_SDW: begin
					k_q     <= k_q + 1'b1;
					state_q <= S_SDR;
				end
				// Open a slot after the split entry.
				S_SUR: state_q <= (k_q > (i_q + 1'b1)) ? S_SUW : S_SPL;
				S_SUW: begin
					k_q     <= k_q - 1'b1;
					state_q <= S_SUR;
				end
				S_SPL: state_q <= S_SPL2;
				S_SPL2: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
			out_st_q    <= res_st_q;
			out_addr_q  <= res_addr_q;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = out_st_q;
	assign alloc_addr = out_addr_q;

	// An accepted item always keeps the sequencer busy for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while sequencer not busy");

	// The table never becomes empty or overfull.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && cnt_q <= MAXC)
		else $error("block count out of range");

	// Only an allocation result carries a nonzero address.
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_ALLOCATED |-> alloc_addr == '0)
		else $error("address on non-allocation result");

endmodule

FILE: design/ffpa_table.sv
module ffpa_table #(
	parameter int POOL_BYTES   = ffpa_pkg::DEF_POOL_BYTES,
	parameter int HEADER_BYTES = ffpa_pkg::DEF_HEADER_BYTES,
	parameter int MAX_BLOCKS   = ffpa_pkg::DEF_MAX_BLOCKS,
	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ffpa_pkg::tbl_wr_t wr,
	input  logic [IW-1:0]    rd_addr,
	output ffpa_pkg::entry_t rd_data
);
	import ffpa_pkg::*;

	localparam entry_t RESET_E0 = '{start: '0,
		size: ADDR_W'(POOL_BYTES - HEADER_BYTES), is_free: 1'b1};

	entry_t        mem [MAX_BLOCKS];
	entry_t        rd_raw_q;
	logic          e0_written_q;
	logic          rd_e0_q;

	// Single write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[IW-1:0]] <= wr.data;
		end
	end

	// Registered read.
	always_ff @(posedge clk) begin
		rd_raw_q <= mem[rd_addr];
	end

	// Entry 0 reads as its reset value until it is first written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e0_written_q <= 1'b0;
			rd_e0_q      <= 1'b0;
		end else begin
			if (wr.en && wr.addr[IW-1:0] == '0) begin
				e0_written_q <= 1'b1;
			end
			rd_e0_q <= (rd_addr == '0) && !e0_written_q;
		end
	end

	assign rd_data = rd_e0_q ? RESET_E0 : rd_raw_q;

endmodule
